// File: hw/rtl/mlcm_pkg.sv
package mlcm_pkg;

  // fixed field widths of the command and response beats
  localparam int unsigned OP_BITS     = 4;
  localparam int unsigned LID_BITS    = 3;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_FIRST,
    OP_LAST,
    OP_NEXT,
    OP_PREV,
    OP_CURRENT,
    OP_INS_AFTER,
    OP_INS_BEFORE,
    OP_APPEND,
    OP_PREPEND,
    OP_REMOVE,
    OP_TRIM,
    OP_COUNT
  } op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK,
    STAT_NONE,
    STAT_FULL
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_EXEC,
    S_LINK,
    S_RESP
  } state_e;

  // node memory port controls
  typedef struct packed {
    logic rd;
    logic item_we;
    logic next_we;
    logic prev_we;
  } mem_ctl_t;

endpackage

// File: hw/rtl/mlcm_node_mem.sv
module mlcm_node_mem import mlcm_pkg::*; #(
  parameter int unsigned NODE_COUNT = 64,
  parameter int unsigned ITEM_BITS  = 32
) (
  input  logic                                clk_i,
  input  mem_ctl_t                            ctl_i,
  input  logic [$clog2(NODE_COUNT)-1:0]       item_addr_i,
  input  logic [$clog2(NODE_COUNT)-1:0]       next_addr_i,
  input  logic [$clog2(NODE_COUNT)-1:0]       prev_addr_i,
  input  logic [ITEM_BITS-1:0]                item_wdata_i,
  input  logic [$clog2(NODE_COUNT+1)-1:0]     next_wdata_i,
  input  logic [$clog2(NODE_COUNT+1)-1:0]     prev_wdata_i,
  output logic [ITEM_BITS-1:0]                item_rdata_o,
  output logic [$clog2(NODE_COUNT+1)-1:0]     next_rdata_o,
  output logic [$clog2(NODE_COUNT+1)-1:0]     prev_rdata_o
);

  localparam int unsigned LW = $clog2(NODE_COUNT + 1);

  logic [ITEM_BITS-1:0] item_mem [NODE_COUNT];
  logic [LW-1:0]        next_mem [NODE_COUNT];
  logic [LW-1:0]        prev_mem [NODE_COUNT];

  // item store: one port, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.item_we) begin
      item_mem[item_addr_i] <= item_wdata_i;
    end else if (ctl_i.rd) begin
      item_rdata_o <= item_mem[item_addr_i];
    end
  end

  // forward links
  always_ff @(posedge clk_i) begin
    if (ctl_i.next_we) begin
      next_mem[next_addr_i] <= next_wdata_i;
    end else if (ctl_i.rd) begin
      next_rdata_o <= next_mem[next_addr_i];
    end
  end

  // backward links
  always_ff @(posedge clk_i) begin
    if (ctl_i.prev_we) begin
      prev_mem[prev_addr_i] <= prev_wdata_i;
    end else if (ctl_i.rd) begin
      prev_rdata_o <= prev_mem[prev_addr_i];
    end
  end

endmodule

// File: hw/rtl/mlcm_free_stack.sv
module mlcm_free_stack #(
  parameter int unsigned NODE_COUNT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(NODE_COUNT)-1:0] rd_addr_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(NODE_COUNT)-1:0] wr_addr_i,
  input  logic [$clog2(NODE_COUNT)-1:0] wr_data_i,
  output logic [$clog2(NODE_COUNT)-1:0] rd_data_o
);

  localparam int unsigned IW = $clog2(NODE_COUNT);

  logic [IW-1:0]         stack_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] vld_q;

  // mark entries once written; an unwritten entry holds its own index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      stack_mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read of the top entry
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= vld_q[rd_addr_i] ? stack_mem[rd_addr_i] : rd_addr_i;
    end
  end

endmodule

// File: hw/rtl/multi_list_cursor_manager_unit.sv
// Sequence: a command beat walks through the read, second read, execute, link fix-up
// and response states to its response beat, a walk set by the single-port node memory.
// Flow: one command in flight; in_stall_o stays high until the response beat
// leaves, and the response beat is held while out_stall_i is high.
// Reset: all lists empty with a null cursor before the start, free stack full.
module multi_list_cursor_manager_unit import mlcm_pkg::*; #(
  parameter int unsigned NODE_COUNT = 64,
  parameter int unsigned NUM_LISTS  = 8,
  parameter int unsigned ITEM_BITS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [OP_BITS-1:0]                operation_i,
  input  logic [LID_BITS-1:0]               list_id_i,
  input  logic [ITEM_BITS-1:0]              item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [STATUS_BITS-1:0]            status_o,
  output logic [ITEM_BITS-1:0]              item_out_o,
  output logic [$clog2(NODE_COUNT+1)-1:0]   length_o
);

  localparam int unsigned IW   = $clog2(NODE_COUNT);
  localparam int unsigned LW   = $clog2(NODE_COUNT + 1);
  localparam int unsigned LIDW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);

  function automatic logic is_node(logic [LW-1:0] x);
    return 32'(x) < NODE_COUNT;
  endfunction

  state_e state_q, state_d;

  // list table
  logic [LW-1:0] head_q [NUM_LISTS];
  logic [LW-1:0] tail_q [NUM_LISTS];
  logic [LW-1:0] curs_q [NUM_LISTS];
  logic          side_q [NUM_LISTS];
  logic [LW-1:0] len_q  [NUM_LISTS];
  logic [LW-1:0] fc_q;

  // command snapshot
  op_e            op_q;
  logic           lid_ok_q;
  logic [LIDW-1:0] lidx_q;
  logic [ITEM_BITS-1:0] item_q;
  logic [LW-1:0]  hd_s_q, tl_s_q, cur_s_q, len_s_q;
  logic           side_s_q;

  // first read results
  logic [ITEM_BITS-1:0] r1_item_q;
  logic [LW-1:0]        r1_next_q, r1_prev_q;

  // link fix-up registers
  logic          lk_next_en_q, lk_prev_en_q;
  logic [LW-1:0] lk_next_a_q, lk_next_d_q, lk_prev_a_q, lk_prev_d_q;

  // response
  logic [STATUS_BITS-1:0] status_q;
  logic [ITEM_BITS-1:0]   item_out_q;
  logic [LW-1:0]          length_q;

  // memory ports
  mem_ctl_t             mctl;
  logic [IW-1:0]        m_item_a, m_next_a, m_prev_a;
  logic [LW-1:0]        m_next_wd, m_prev_wd;
  logic [ITEM_BITS-1:0] m_item_rd;
  logic [LW-1:0]        m_next_rd, m_prev_rd;
  logic                 fs_rd_en, fs_wr_en;
  logic [IW-1:0]        fs_rd_a, fs_rdata;

  // execute results
  status_e              x_st;
  logic [ITEM_BITS-1:0] x_res;
  logic [LW-1:0]        x_h, x_t, x_c, x_l, x_fc, x_n, x_p, x_q, x_tg;
  logic                 x_s, x_node_we, x_push;
  logic                 x_lk_next_en, x_lk_prev_en;
  logic [LW-1:0]        x_lk_next_a, x_lk_next_d, x_lk_prev_a, x_lk_prev_d;
  logic [LW-1:0]        rd1_a;
  logic                 accept;
  logic [LIDW-1:0]      lidx_in;

  assign accept  = in_valid_i && !in_stall_o;
  assign lidx_in = LIDW'(list_id_i);

  mlcm_node_mem #(
    .NODE_COUNT (NODE_COUNT),
    .ITEM_BITS  (ITEM_BITS)
  ) u_node_mem (
    .clk_i        (clk_i),
    .ctl_i        (mctl),
    .item_addr_i  (m_item_a),
    .next_addr_i  (m_next_a),
    .prev_addr_i  (m_prev_a),
    .item_wdata_i (item_q),
    .next_wdata_i (m_next_wd),
    .prev_wdata_i (m_prev_wd),
    .item_rdata_o (m_item_rd),
    .next_rdata_o (m_next_rd),
    .prev_rdata_o (m_prev_rd)
  );

  mlcm_free_stack #(
    .NODE_COUNT (NODE_COUNT)
  ) u_free_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (fs_rd_en),
    .rd_addr_i (fs_rd_a),
    .wr_en_i   (fs_wr_en),
    .wr_addr_i (fc_q[IW-1:0]),
    .wr_data_i (x_tg[IW-1:0]),
    .rd_data_o (fs_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_RD1;
      S_RD1:   state_d = S_RD2;
      S_RD2:   state_d = S_EXEC;
      S_EXEC:  state_d = S_LINK;
      S_LINK:  state_d = S_RESP;
      S_RESP:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // first read address per operation
  always_comb begin
    unique case (op_q)
      OP_FIRST: rd1_a = hd_s_q;
      OP_LAST:  rd1_a = tl_s_q;
      OP_NEXT:  rd1_a = is_node(cur_s_q) ? cur_s_q : hd_s_q;
      OP_PREV:  rd1_a = is_node(cur_s_q) ? cur_s_q : tl_s_q;
      OP_TRIM:  rd1_a = tl_s_q;
      default:  rd1_a = cur_s_q;
    endcase
  end

  // execute: work out list, node and free stack updates
  always_comb begin
    x_st = STAT_NONE;
    x_res = '0;
    x_h = hd_s_q;
    x_t = tl_s_q;
    x_c = cur_s_q;
    x_s = side_s_q;
    x_l = len_s_q;
    x_fc = fc_q;
    x_n = LW'(fs_rdata);
    x_p = NIL;
    x_q = NIL;
    x_tg = cur_s_q;
    x_node_we = 1'b0;
    x_push = 1'b0;
    x_lk_next_en = 1'b0;
    x_lk_prev_en = 1'b0;
    x_lk_next_a = NIL;
    x_lk_next_d = NIL;
    x_lk_prev_a = NIL;
    x_lk_prev_d = NIL;
    if (lid_ok_q) begin
      unique case (op_q)
        OP_FIRST, OP_LAST: begin
          x_c = (op_q == OP_FIRST) ? hd_s_q : tl_s_q;
          if (is_node(x_c)) begin
            x_st = STAT_OK;
            x_res = r1_item_q;
          end
        end
        OP_NEXT: begin
          if (!is_node(cur_s_q)) begin
            if (!side_s_q) begin
              if (is_node(hd_s_q)) begin
                x_c = hd_s_q;
                x_st = STAT_OK;
                x_res = r1_item_q;
              end else begin
                x_s = 1'b1;
              end
            end
          end else begin
            x_c = r1_next_q;
            if (is_node(r1_next_q)) begin
              x_st = STAT_OK;
              x_res = m_item_rd;
            end else begin
              x_s = 1'b1;
            end
          end
        end
        OP_PREV: begin
          if (!is_node(cur_s_q)) begin
            if (side_s_q) begin
              if (is_node(tl_s_q)) begin
                x_c = tl_s_q;
                x_st = STAT_OK;
                x_res = r1_item_q;
              end else begin
                x_s = 1'b0;
              end
            end
          end else begin
            x_c = r1_prev_q;
            if (is_node(r1_prev_q)) begin
              x_st = STAT_OK;
              x_res = m_item_rd;
            end else begin
              x_s = 1'b0;
            end
          end
        end
        OP_CURRENT: begin
          if (is_node(cur_s_q)) begin
            x_st = STAT_OK;
            x_res = r1_item_q;
          end
        end
        OP_INS_AFTER, OP_INS_BEFORE, OP_APPEND, OP_PREPEND: begin
          if (fc_q == '0) begin
            x_st = STAT_FULL;
          end else begin
            priority if (op_q == OP_APPEND ||
                         (op_q != OP_PREPEND && !is_node(cur_s_q) && side_s_q)) begin
              x_p = tl_s_q;
              x_q = NIL;
            end else if (op_q == OP_PREPEND || !is_node(cur_s_q)) begin
              x_p = NIL;
              x_q = hd_s_q;
            end else if (op_q == OP_INS_AFTER) begin
              x_p = cur_s_q;
              x_q = r1_next_q;
            end else begin
              x_p = r1_prev_q;
              x_q = cur_s_q;
            end
            x_node_we = 1'b1;
            if (!is_node(x_p)) x_h = x_n;
            if (!is_node(x_q)) x_t = x_n;
            x_l = len_s_q + 1'b1;
            x_c = x_n;
            x_fc = fc_q - 1'b1;
            x_lk_next_en = is_node(x_p);
            x_lk_next_a = x_p;
            x_lk_next_d = x_n;
            x_lk_prev_en = is_node(x_q);
            x_lk_prev_a = x_q;
            x_lk_prev_d = x_n;
            x_st = STAT_OK;
            x_res = item_q;
          end
        end
        OP_REMOVE, OP_TRIM: begin
          x_tg = (op_q == OP_REMOVE) ? cur_s_q : tl_s_q;
          if (is_node(x_tg)) begin
            x_res = r1_item_q;
            x_p = r1_prev_q;
            x_q = r1_next_q;
            if (!is_node(x_p)) x_h = x_q;
            if (!is_node(x_q)) x_t = x_p;
            if (len_s_q != '0) x_l = len_s_q - 1'b1;
            if (32'(fc_q) < NODE_COUNT) begin
              x_push = 1'b1;
              x_fc = fc_q + 1'b1;
            end
            x_lk_next_en = is_node(x_p);
            x_lk_next_a = x_p;
            x_lk_next_d = x_q;
            x_lk_prev_en = is_node(x_q);
            x_lk_prev_a = x_q;
            x_lk_prev_d = x_p;
            x_c = (op_q == OP_REMOVE) ? x_q : x_t;
            if (!is_node(x_c)) x_s = 1'b1;
            x_st = STAT_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // memory and free stack strobes per state
  always_comb begin
    mctl = '0;
    m_item_a = rd1_a[IW-1:0];
    m_next_a = rd1_a[IW-1:0];
    m_prev_a = rd1_a[IW-1:0];
    m_next_wd = x_q;
    m_prev_wd = x_p;
    fs_rd_en = 1'b0;
    fs_rd_a = IW'(fc_q - 1'b1);
    fs_wr_en = 1'b0;
    unique case (state_q)
      S_RD1: begin
        mctl.rd = 1'b1;
        fs_rd_en = 1'b1;
      end
      S_RD2: begin
        mctl.rd = 1'b1;
        m_item_a = (op_q == OP_PREV) ? m_prev_rd[IW-1:0] : m_next_rd[IW-1:0];
        m_next_a = m_item_a;
        m_prev_a = m_item_a;
      end
      S_EXEC: begin
        mctl.item_we = x_node_we;
        mctl.next_we = x_node_we;
        mctl.prev_we = x_node_we;
        m_item_a = x_n[IW-1:0];
        m_next_a = x_n[IW-1:0];
        m_prev_a = x_n[IW-1:0];
        fs_wr_en = x_push;
      end
      S_LINK: begin
        mctl.next_we = lk_next_en_q;
        mctl.prev_we = lk_prev_en_q;
        m_next_a = lk_next_a_q[IW-1:0];
        m_prev_a = lk_prev_a_q[IW-1:0];
        m_next_wd = lk_next_d_q;
        m_prev_wd = lk_prev_d_q;
      end
      default: begin
      end
    endcase
  end

  // control state and list table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fc_q <= LW'(NODE_COUNT);
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
        curs_q[i] <= NIL;
        side_q[i] <= 1'b0;
        len_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC && lid_ok_q) begin
        fc_q <= x_fc;
        head_q[lidx_q] <= x_h;
        tail_q[lidx_q] <= x_t;
        curs_q[lidx_q] <= is_node(x_c) ? x_c : NIL;
        side_q[lidx_q] <= x_s;
        len_q[lidx_q]  <= x_l;
      end
    end
  end

  // capture the command beat and datapath results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_e'(operation_i);
      lid_ok_q <= 32'(list_id_i) < NUM_LISTS;
      lidx_q   <= lidx_in;
      item_q   <= item_i;
      hd_s_q   <= head_q[lidx_in];
      tl_s_q   <= tail_q[lidx_in];
      cur_s_q  <= is_node(curs_q[lidx_in]) ? curs_q[lidx_in] : NIL;
      side_s_q <= side_q[lidx_in];
      len_s_q  <= len_q[lidx_in];
    end
    if (state_q == S_RD2) begin
      r1_item_q <= m_item_rd;
      r1_next_q <= m_next_rd;
      r1_prev_q <= m_prev_rd;
    end
    if (state_q == S_EXEC) begin
      lk_next_en_q <= x_lk_next_en;
      lk_next_a_q  <= x_lk_next_a;
      lk_next_d_q  <= x_lk_next_d;
      lk_prev_en_q <= x_lk_prev_en;
      lk_prev_a_q  <= x_lk_prev_a;
      lk_prev_d_q  <= x_lk_prev_d;
      status_q     <= x_st;
      item_out_q   <= (x_st == STAT_OK) ? x_res : '0;
      length_q     <= lid_ok_q ? x_l : '0;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = state_q == S_RESP;
  assign status_o    = status_q;
  assign item_out_o  = item_out_q;
  assign length_o    = length_q;

  // free count never exceeds the pool
  a_fc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fc_q) <= NODE_COUNT)
    else $error("free count beyond pool size");

  // no command taken while a response beat is pending
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("command accepted with response pending");

  // a response without an item carries a zero handle
  a_zero_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> (item_out_o == '0))
    else $error("item handle on a failed response");

  // a list never holds more items than the pool
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(length_o) <= NODE_COUNT))
    else $error("list length beyond pool size");

endmodule
